FILE: rtl/core/kscl_pkg.sv
// Package for the keypad scan code lock: sizes, key codes and key patterns.
package kscl_pkg;

  localparam int CodeLength = 11;
  localparam int CodeW      = 44;
  localparam int CodeDigits = CodeW / 4;
  localparam int ColW       = 4;
  localparam int RowW       = 2;
  localparam int NumRows    = 4;
  localparam int MapW       = NumRows * ColW;
  localparam int KeyW       = 4;
  localparam int DigitW     = 4;
  localparam int CntW       = $clog2(CodeLength + 1);
  localparam int BufW       = CodeLength * DigitW;
  localparam int PadW       = (BufW > CodeW) ? BufW : CodeW;
  localparam int NumKeys    = 13;

  localparam logic [CodeW-1:0] CodeReset = 44'h910_0050_4346;

  localparam logic [KeyW-1:0] KeyOk    = 4'd10;
  localparam logic [KeyW-1:0] KeyBksp  = 4'd11;
  localparam logic [KeyW-1:0] KeyClear = 4'd12;

  localparam logic [NumKeys-1:0][MapW-1:0] KeyPattern = {
    16'h1000, 16'h2000, 16'h8000, 16'h0100, 16'h0010, 16'h0001, 16'h0200,
    16'h0020, 16'h0002, 16'h0400, 16'h0040, 16'h0004, 16'h0008
  };

endpackage

FILE: rtl/core/kscl_in_if.sv
// Request channel carrying one scan tick of column levels.
interface kscl_in_if;
  import kscl_pkg::*;

  logic            valid;
  logic            ready;
  logic [ColW-1:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink (input valid, input column_levels, output ready);
endinterface

FILE: rtl/core/kscl_out_if.sv
// Result channel carrying scan row, lock status and decoded key.
interface kscl_out_if;
  import kscl_pkg::*;

  logic            valid;
  logic            ready;
  logic [RowW-1:0] row_to_drive_low;
  logic            match_light;
  logic [3:0]      digits_entered;
  logic            key_valid;
  logic [KeyW-1:0] key_value;

  modport source (output valid, output row_to_drive_low, output match_light,
                  output digits_entered, output key_valid, output key_value,
                  input ready);
  modport sink (input valid, input row_to_drive_low, input match_light,
                input digits_entered, input key_valid, input key_value,
                output ready);
endinterface

FILE: rtl/core/keypad_scan_code_lock.sv
// Keypad scanner with digit code lock: one request is one scan tick of a 4x4 matrix.
// Each request updates the driven row's nibble of the pressed-key map, steps the row
// and, on a new press of exactly one mapped key, acts on it (digit, OK, backspace,
// clear). One request is taken per clock cycle unless stalled; its result appears in
// the output register on the next cycle, and a new request is taken while that result
// is being read. The secret code may be written only while no request is in flight.
module keypad_scan_code_lock
  import kscl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CodeW-1:0] cfg_wdata_i,
  kscl_in_if.sink          in_i,
  kscl_out_if.source       out_o
);

  logic [CodeW-1:0]                    secret_q;
  logic [MapW-1:0]                     map_q, map_d;
  logic [RowW-1:0]                     row_q, row_d;
  logic                                was_q, was_d;
  logic [CntW-1:0]                     cnt_q, cnt_d;
  logic [CodeLength-1:0][DigitW-1:0]   ent_q, ent_d;
  logic                                match_q, match_d;
  logic                                out_valid_q;
  logic                                key_valid_q, key_valid_d;
  logic [KeyW-1:0]                     key_value_q, key_value_d;

  logic            in_fire;
  logic            now_pressed;
  logic            hit;
  logic [KeyW-1:0] key;
  logic [PadW-1:0] code_pad;
  logic            code_ok;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign code_pad = PadW'(secret_q);
  assign code_ok  = (ent_q == code_pad[BufW-1:0]);

  always_comb begin
    map_d       = map_q;
    row_d       = row_q;
    was_d       = was_q;
    cnt_d       = cnt_q;
    ent_d       = ent_q;
    match_d     = match_q;
    key_valid_d = 1'b0;
    key_value_d = '0;
    now_pressed = 1'b0;
    hit         = 1'b0;
    key         = '0;
    if (in_fire) begin
      for (int r = 0; r < NumRows; r++) begin
        if (row_q == RowW'(r)) begin
          map_d[r*ColW +: ColW] = ~in_i.column_levels;
        end
      end
      row_d       = row_q + RowW'(1);
      now_pressed = |map_d;
      for (int j = 0; j < NumKeys; j++) begin
        if (map_d == KeyPattern[j]) begin
          hit = 1'b1;
          key = KeyW'(j);
        end
      end
      if (now_pressed && !was_q && hit) begin
        key_valid_d = 1'b1;
        key_value_d = key;
        if (key < KeyOk) begin
          if (cnt_q < CntW'(CodeLength)) begin
            for (int i = 0; i < CodeLength; i++) begin
              if (cnt_q == CntW'(i)) begin
                ent_d[i] = key;
              end
            end
            cnt_d = cnt_q + CntW'(1);
          end
        end else if (key == KeyOk) begin
          match_d = code_ok;
        end else if (key == KeyBksp) begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CntW'(1);
            for (int i = 0; i < CodeLength; i++) begin
              if (cnt_d == CntW'(i)) begin
                ent_d[i] = '0;
              end
            end
          end
        end else begin
          cnt_d = '0;
          ent_d = '0;
        end
      end
      was_d = now_pressed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secret_q    <= CodeReset;
      map_q       <= '0;
      row_q       <= '0;
      was_q       <= 1'b0;
      cnt_q       <= '0;
      ent_q       <= '0;
      match_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        secret_q <= cfg_wdata_i;
      end
      map_q   <= map_d;
      row_q   <= row_d;
      was_q   <= was_d;
      cnt_q   <= cnt_d;
      ent_q   <= ent_d;
      match_q <= match_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_valid_q <= key_valid_d;
      key_value_q <= key_value_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.row_to_drive_low = row_q;
  assign out_o.match_light      = match_q;
  assign out_o.digits_entered   = 4'(cnt_q);
  assign out_o.key_valid        = key_valid_q;
  assign out_o.key_value        = key_value_q;

endmodule

FILE: bench/testbench.sv
// Testbench for the keypad scan code lock: scan-tick stimulus, lock predictor, result checks.
`timescale 1ns / 1ps

module testbench;
  import kscl_pkg::*;

  typedef struct packed {
    logic [RowW-1:0] row_to_drive_low;
    logic            match_light;
    logic [3:0]      digits_entered;
    logic            key_valid;
    logic [KeyW-1:0] key_value;
  } lock_status_t;

  class lock_scoreboard;
    logic [CodeW-1:0]   code;
    logic [MapW-1:0]    key_map;
    logic [RowW-1:0]    row;
    bit                 held;
    int unsigned        count;
    logic [DigitW-1:0]  digits [CodeLength];
    bit                 lit;
    lock_status_t       due_q[$];
    int                 errors;
    int                 checked;
    int                 keys_seen;
    int                 matches_seen;

    function void reset_state();
      code    = CodeReset;
      key_map = '0;
      row     = '0;
      held    = 1'b0;
      count   = 0;
      lit     = 1'b0;
      foreach (digits[i]) digits[i] = '0;
    endfunction

    function void set_code(logic [CodeW-1:0] value);
      code = value;
    endfunction

    function bit buffer_matches();
      bit ok;
      ok = 1'b1;
      for (int i = 0; i < CodeLength; i++) begin
        if (i < CodeDigits) begin
          if (digits[i] != code[i*DigitW +: DigitW]) ok = 1'b0;
        end else if (digits[i] != '0) begin
          ok = 1'b0;
        end
      end
      return ok;
    endfunction

    // one accepted scan tick
    function void note_tick(logic [ColW-1:0] levels);
      lock_status_t st;
      bit           now_pressed;
      int           key;
      key = -1;
      key_map[int'(row)*ColW +: ColW] = ~levels;
      row = row + 1'b1;
      now_pressed = key_map != '0;
      st = '0;
      if (now_pressed && !held) begin
        for (int k = 0; k < NumKeys; k++)
          if (key == -1 && key_map == KeyPattern[k]) key = k;
      end
      if (key >= 0) begin
        st.key_valid = 1'b1;
        st.key_value = KeyW'(key);
        keys_seen++;
        if (key < KeyOk) begin
          if (count < CodeLength) begin
            digits[count] = DigitW'(key);
            count++;
          end
        end else if (key == KeyOk) begin
          lit = buffer_matches();
          if (lit) matches_seen++;
        end else if (key == KeyBksp) begin
          if (count > 0) begin
            count--;
            digits[count] = '0;
          end
        end else begin
          count = 0;
          foreach (digits[i]) digits[i] = '0;
        end
      end
      held = now_pressed;
      st.row_to_drive_low = row;
      st.match_light      = lit;
      st.digits_entered   = count[3:0];
      due_q.push_back(st);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(lock_status_t got);
      lock_status_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.row_to_drive_low !== want.row_to_drive_low)
        report($sformatf("row_to_drive_low got %0d want %0d (result %0d)",
                         got.row_to_drive_low, want.row_to_drive_low, checked));
      if (got.match_light !== want.match_light)
        report($sformatf("match_light got %0b want %0b (result %0d)",
                         got.match_light, want.match_light, checked));
      if (got.digits_entered !== want.digits_entered)
        report($sformatf("digits_entered got %0d want %0d (result %0d)",
                         got.digits_entered, want.digits_entered, checked));
      if (got.key_valid !== want.key_valid)
        report($sformatf("key_valid got %0b want %0b (result %0d)",
                         got.key_valid, want.key_valid, checked));
      if (got.key_value !== want.key_value)
        report($sformatf("key_value got %0d want %0d (result %0d)",
                         got.key_value, want.key_value, checked));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CodeW-1:0] cfg_wdata_i;

  kscl_in_if  in_ch ();
  kscl_out_if out_ch ();

  keypad_scan_code_lock i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  lock_scoreboard  sb;
  bit              calm;
  logic [RowW-1:0] drive_row;
  int              ticks_sent;
  int              code_writes;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #400_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // request side
  task automatic send_tick(input logic [ColW-1:0] levels);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid         = 1'b0;
      in_ch.column_levels = ColW'($urandom);
      @(negedge clk_i);
    end
    in_ch.valid         = 1'b1;
    in_ch.column_levels = levels;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_tick(levels);
    drive_row = drive_row + 1'b1;
    ticks_sent++;
  endtask

  task automatic hold_map(input logic [MapW-1:0] map, input int ticks);
    repeat (ticks) send_tick(~map[int'(drive_row)*ColW +: ColW]);
  endtask

  task automatic release_all(input int ticks);
    repeat (ticks) send_tick('1);
  endtask

  task automatic press_key(input int key);
    hold_map(KeyPattern[key], $urandom_range(6, 4));
    release_all($urandom_range(6, 4));
  endtask

  task automatic write_code(input logic [CodeW-1:0] value);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.due_q.size() != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_code(value);
    code_writes++;
  endtask

  // clear, type digits (right or random), optional fixup, OK
  task automatic enter_code(input bit exact, input int len);
    int          digit;
    logic [3:0]  nib;
    press_key(KeyClear);
    for (int i = 0; i < len; i++) begin
      nib = (i < CodeDigits) ? sb.code[i*DigitW +: DigitW] : 4'd0;
      digit = (exact && nib < KeyOk) ? int'(nib) : $urandom_range(9);
      if ($urandom_range(9) == 0) begin
        press_key($urandom_range(9));
        press_key(KeyBksp);
      end
      press_key(digit);
    end
    press_key(KeyOk);
  endtask

  task automatic noise_burst();
    logic [MapW-1:0] map;
    case ($urandom_range(3))
      0: repeat ($urandom_range(8, 1)) send_tick(ColW'($urandom));
      1: begin
        map = KeyPattern[$urandom_range(NumKeys - 1)] |
              KeyPattern[$urandom_range(NumKeys - 1)];
        hold_map(map, $urandom_range(6, 4));
      end
      2: begin
        hold_map(KeyPattern[$urandom_range(NumKeys - 1)], $urandom_range(3, 1));
        hold_map(KeyPattern[$urandom_range(NumKeys - 1)], $urandom_range(6, 1));
      end
      default: hold_map(MapW'($urandom), $urandom_range(8, 1));
    endcase
    release_all($urandom_range(6, 4));
  endtask

  function automatic logic [CodeW-1:0] digit_code();
    logic [CodeW-1:0] value;
    for (int i = 0; i < CodeDigits; i++) value[i*DigitW +: DigitW] = DigitW'($urandom_range(9));
    return value;
  endfunction

  // result side
  initial begin
    lock_status_t got;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      out_ch.ready = calm || ($urandom_range(99) >= 28);
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        got.row_to_drive_low = out_ch.row_to_drive_low;
        got.match_light      = out_ch.match_light;
        got.digits_entered   = out_ch.digits_entered;
        got.key_valid        = out_ch.key_valid;
        got.key_value        = out_ch.key_value;
        sb.check_result(got);
      end
    end
  end

  initial begin
    logic [CodeW-1:0] phase_code;
    int               phase_end;
    sb = new();
    sb.reset_state();
    calm                = 1'b0;
    drive_row           = '0;
    ticks_sent          = 0;
    code_writes         = 0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    in_ch.valid         = 1'b0;
    in_ch.column_levels = '1;
    rst_ni              = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: column extremes, the reset code, full buffer, backspace, clear
    send_tick('0);
    release_all(4);
    enter_code(1'b1, CodeLength);
    press_key(7);
    press_key(KeyOk);
    press_key(KeyBksp);
    press_key(KeyOk);
    press_key(KeyClear);
    press_key(KeyBksp);
    press_key(2);
    press_key(8);
    hold_map(KeyPattern[1] | KeyPattern[2], 5);
    release_all(4);

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       phase_code = '0;
        1:       phase_code = '1;
        5:       phase_code = CodeW'({$urandom, $urandom});
        6:       phase_code = CodeReset;
        default: phase_code = digit_code();
      endcase
      write_code(phase_code);
      calm = (phase == 3);
      if (phase == 0) press_key(KeyOk);
      phase_end = ticks_sent + 175;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(99) < 65)
          enter_code($urandom_range(3) != 0,
                     ($urandom_range(3) == 0) ? $urandom_range(12) : CodeLength);
        else
          noise_burst();
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("ran %0d scan ticks under %0d code settings, checked %0d results",
             ticks_sent, code_writes, sb.checked);
    $display("decoded %0d keys, %0d code matches, %0d mismatches",
             sb.keys_seen, sb.matches_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
